[rtl/packet_direction_byte_counter_defines.svh]
// Assertion macros used by the packet direction byte counter RTL.
`ifndef PACKET_DIRECTION_BYTE_COUNTER_DEFINES_SVH
`define PACKET_DIRECTION_BYTE_COUNTER_DEFINES_SVH

// The property must hold in the same cycle as the trigger.
`define PDBC_ASSERT_SAME(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after the trigger.
`define PDBC_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

[rtl/pdbc_pkg.sv]
package pdbc_pkg;

    // Width of the summed header length in bytes.
    localparam int HDR_W = 8;

    // Direction codes.
    localparam logic [1:0] DIR_FROM_HOST = 2'd0;
    localparam logic [1:0] DIR_TO_HOST   = 2'd1;
    localparam logic [1:0] DIR_NEITHER   = 2'd2;
    localparam logic [1:0] DIR_NOT_IP    = 2'd3;

    // Protocol class codes.
    localparam logic [1:0] CLS_TCP     = 2'd0;
    localparam logic [1:0] CLS_TCP_BAD = 2'd1;
    localparam logic [1:0] CLS_UDP     = 2'd2;
    localparam logic [1:0] CLS_OTHER   = 2'd3;

    // Counter slot within one direction's block of class counters.
    localparam logic [1:0] SLOT_TCP   = 2'd0;
    localparam logic [1:0] SLOT_UDP   = 2'd1;
    localparam logic [1:0] SLOT_OTHER = 2'd2;

    // Protocol numbers and header sizes.
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
    localparam logic [HDR_W-1:0] UDP_HDR_BYTES = HDR_W'(8);

    // Frame held in the update stage.
    typedef struct packed {
        logic [1:0]  dir;
        logic [1:0]  cls;
        logic [15:0] payload;
        logic [2:0]  cls_addr;
    } stage_t;

    // One result waiting in the output queue.
    typedef struct packed {
        logic [1:0]  direction;
        logic [1:0]  protocol_class;
        logic [15:0] payload_bytes;
        logic [63:0] uplink_total;
        logic [63:0] downlink_total;
        logic [31:0] packet_total;
        logic [31:0] category_count;
    } result_t;

endpackage

[rtl/pdbc_ram.sv]
module pdbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/packet_direction_byte_counter.sv]
// A request's result is registered in the update stage and then written into the
// output queue, from which it is offered.
// Throughput: one request per cycle while the input is not stalled; the counter
// memories are read at acceptance and written back from the update stage, with one-deep forwarding.
// The input stalls while the update stage and the output queue hold three results.
// Reset: all counters read as zero (per-entry valid bits), host address 0,
// output queue empty. No clearing pass is needed.
`include "packet_direction_byte_counter_defines.svh"

module packet_direction_byte_counter
    import pdbc_pkg::*;
#(
    parameter int ETH_HEADER_BYTES = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] host_address,
    // Input request channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] frame_length,
    input  logic [3:0]  ip_header_words,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    input  logic [7:0]  protocol_number,
    input  logic [3:0]  tcp_offset_words,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  direction,
    output logic [1:0]  protocol_class,
    output logic [15:0] payload_bytes,
    output logic [63:0] uplink_total,
    output logic [63:0] downlink_total,
    output logic [31:0] packet_total,
    output logic [31:0] category_count
);

    localparam logic [1:0] FIFO_DEPTH = 2'd3;

    logic [31:0]   host_address_reg;

    logic          in_accept;
    stage_t        s0;
    logic [HDR_W-1:0] hdr0;
    logic          s1_valid_reg;
    stage_t        s1_reg;

    logic [31:0]   ip_rdata;
    logic [31:0]   cls_rdata;
    logic          ip_rvalid_reg;
    logic          cls_rvalid_reg;
    logic [1:0]    ip_valid_reg;
    logic [7:0]    cls_valid_reg;

    logic          fwd_ip_valid_reg;
    logic          fwd_ip_addr_reg;
    logic [31:0]   fwd_ip_data_reg;
    logic          fwd_cls_valid_reg;
    logic [2:0]    fwd_cls_addr_reg;
    logic [31:0]   fwd_cls_data_reg;

    logic [31:0]   ip_cur;
    logic [31:0]   ip_new;
    logic [31:0]   cls_cur;
    logic [31:0]   cls_new;
    logic          counted;
    logic          ip_we;
    logic          cls_we;

    logic [31:0]   frames_reg;
    logic [31:0]   frames_next;
    logic [63:0]   up_reg;
    logic [63:0]   up_next;
    logic [63:0]   down_reg;
    logic [63:0]   down_next;
    result_t       push_entry;

    result_t       fifo_mem [3];
    logic [1:0]    wr_ptr_reg;
    logic [1:0]    rd_ptr_reg;
    logic [1:0]    fifo_count_reg;
    logic [1:0]    fifo_count_next;
    logic          fifo_push;
    logic          fifo_pop;
    logic [2:0]    occupancy;
    result_t       head;

    // Configuration register; always ready. The user must write it only while idle; the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_address_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            host_address_reg <= host_address;
        end
    end

    // Stall when the update stage and the queue could not take one more.
    assign occupancy = {1'b0, fifo_count_reg} + {2'b00, s1_valid_reg};
    assign in_stall  = (occupancy >= {1'b0, FIFO_DEPTH});
    assign in_accept = in_valid && !in_stall;

    // Classification of the incoming request.
    always_comb
    begin
        s0   = '0;
        hdr0 = HDR_W'(ETH_HEADER_BYTES) + {{(HDR_W-6){1'b0}}, ip_header_words, 2'b00};
        if (ip_header_words < MIN_HDR_WORDS)
        begin
            s0.dir = DIR_NOT_IP;
            s0.cls = CLS_OTHER;
        end
        else
        begin
            if (source_address == host_address_reg)
            begin
                s0.dir = DIR_FROM_HOST;
            end
            else if (dest_address == host_address_reg)
            begin
                s0.dir = DIR_TO_HOST;
            end
            else
            begin
                s0.dir = DIR_NEITHER;
            end
            if (protocol_number == PROTO_TCP)
            begin
                if (tcp_offset_words < MIN_HDR_WORDS)
                begin
                    s0.cls = CLS_TCP_BAD;
                end
                else
                begin
                    s0.cls = CLS_TCP;
                    hdr0   = hdr0 + {{(HDR_W-6){1'b0}}, tcp_offset_words, 2'b00};
                end
                s0.cls_addr = {s0.dir[0], SLOT_TCP};
            end
            else if (protocol_number == PROTO_UDP)
            begin
                s0.cls      = CLS_UDP;
                hdr0        = hdr0 + UDP_HDR_BYTES;
                s0.cls_addr = {s0.dir[0], SLOT_UDP};
            end
            else
            begin
                s0.cls      = CLS_OTHER;
                s0.cls_addr = {s0.dir[0], SLOT_OTHER};
            end
            if (frame_length > {{(16-HDR_W){1'b0}}, hdr0})
            begin
                s0.payload = frame_length - {{(16-HDR_W){1'b0}}, hdr0};
            end
        end
    end

    // Counter memories: per-direction IP frames and per-class frames.
    pdbc_ram #(
        .WIDTH (32),
        .DEPTH (2)
    ) u_ip_ram (
        .clk     (clk),
        .wr_en   (ip_we),
        .wr_addr (s1_reg.dir[0]),
        .wr_data (ip_new),
        .rd_addr (s0.dir[0]),
        .rd_data (ip_rdata)
    );

    pdbc_ram #(
        .WIDTH (32),
        .DEPTH (8)
    ) u_cls_ram (
        .clk     (clk),
        .wr_en   (cls_we),
        .wr_addr (s1_reg.cls_addr),
        .wr_data (cls_new),
        .rd_addr (s0.cls_addr),
        .rd_data (cls_rdata)
    );

    // Update stage: pick forwarded, stored or reset value and increment.
    always_comb
    begin
        if (fwd_ip_valid_reg && (fwd_ip_addr_reg == s1_reg.dir[0]))
        begin
            ip_cur = fwd_ip_data_reg;
        end
        else
        begin
            ip_cur = ip_rvalid_reg ? ip_rdata : '0;
        end
        if (fwd_cls_valid_reg && (fwd_cls_addr_reg == s1_reg.cls_addr))
        begin
            cls_cur = fwd_cls_data_reg;
        end
        else
        begin
            cls_cur = cls_rvalid_reg ? cls_rdata : '0;
        end
    end

    assign ip_new  = ip_cur + 32'd1;
    assign cls_new = cls_cur + 32'd1;
    assign counted = s1_valid_reg && (s1_reg.dir[1] == 1'b0);
    assign ip_we   = counted;
    assign cls_we  = counted && (s1_reg.cls != CLS_TCP_BAD);

    // Running totals.
    assign frames_next = s1_valid_reg ? frames_reg + 32'd1 : frames_reg;
    assign up_next     = (s1_valid_reg && (s1_reg.dir == DIR_FROM_HOST))
                         ? up_reg + {48'd0, s1_reg.payload} : up_reg;
    assign down_next   = (s1_valid_reg && (s1_reg.dir == DIR_TO_HOST))
                         ? down_reg + {48'd0, s1_reg.payload} : down_reg;

    // Result assembled at the end of the update stage.
    always_comb
    begin
        push_entry                = '0;
        push_entry.direction      = s1_reg.dir;
        push_entry.protocol_class = s1_reg.cls;
        push_entry.payload_bytes  = s1_reg.payload;
        push_entry.uplink_total   = up_next;
        push_entry.downlink_total = down_next;
        push_entry.packet_total   = frames_next;
        if (counted)
        begin
            push_entry.category_count = (s1_reg.cls == CLS_TCP_BAD) ? ip_new : cls_new;
        end
    end

    // Control registers of the pipeline and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            ip_rvalid_reg     <= 1'b0;
            cls_rvalid_reg    <= 1'b0;
            ip_valid_reg      <= '0;
            cls_valid_reg     <= '0;
            fwd_ip_valid_reg  <= 1'b0;
            fwd_cls_valid_reg <= 1'b0;
            frames_reg        <= '0;
            up_reg            <= '0;
            down_reg          <= '0;
        end
        else
        begin
            s1_valid_reg      <= in_accept;
            ip_rvalid_reg     <= ip_valid_reg[s0.dir[0]];
            cls_rvalid_reg    <= cls_valid_reg[s0.cls_addr];
            fwd_ip_valid_reg  <= ip_we;
            fwd_cls_valid_reg <= cls_we;
            frames_reg        <= frames_next;
            up_reg            <= up_next;
            down_reg          <= down_next;
            if (ip_we)
            begin
                ip_valid_reg[s1_reg.dir[0]] <= 1'b1;
            end
            if (cls_we)
            begin
                cls_valid_reg[s1_reg.cls_addr] <= 1'b1;
            end
        end
    end

    // Stage payload and forwarding data.
    always_ff @(posedge clk)
    begin
        s1_reg           <= s0;
        fwd_ip_addr_reg  <= s1_reg.dir[0];
        fwd_ip_data_reg  <= ip_new;
        fwd_cls_addr_reg <= s1_reg.cls_addr;
        fwd_cls_data_reg <= cls_new;
    end

    // Output queue of three results.
    assign fifo_push = s1_valid_reg;
    assign fifo_pop  = out_valid && !out_stall;

    always_comb
    begin
        fifo_count_next = fifo_count_reg;
        if (fifo_push && !fifo_pop)
        begin
            fifo_count_next = fifo_count_reg + 2'd1;
        end
        else if (!fifo_push && fifo_pop)
        begin
            fifo_count_next = fifo_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            fifo_count_reg <= fifo_count_next;
            if (fifo_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_DEPTH - 2'd1) ? 2'd0 : wr_ptr_reg + 2'd1;
            end
            if (fifo_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_DEPTH - 2'd1) ? 2'd0 : rd_ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head           = fifo_mem[rd_ptr_reg];
    assign out_valid      = (fifo_count_reg != 2'd0);
    assign direction      = head.direction;
    assign protocol_class = head.protocol_class;
    assign payload_bytes  = head.payload_bytes;
    assign uplink_total   = head.uplink_total;
    assign downlink_total = head.downlink_total;
    assign packet_total   = head.packet_total;
    assign category_count = head.category_count;

    // Checks on queue room, counter updates and classification.
    `PDBC_ASSERT_SAME(a_no_overflow, clk, rst_n, fifo_push && !fifo_pop,
        fifo_count_reg != FIFO_DEPTH, "output queue overflow")
    `PDBC_ASSERT_SAME(a_cls_needs_ip, clk, rst_n, cls_we, ip_we,
        "class counter written without IP counter")
    `PDBC_ASSERT_NEXT(a_frame_count, clk, rst_n, s1_valid_reg,
        frames_reg == $past(frames_reg) + 32'd1, "frame count did not advance")
    `PDBC_ASSERT_NEXT(a_not_ip, clk, rst_n, in_accept && (ip_header_words < MIN_HDR_WORDS),
        s1_reg.dir == DIR_NOT_IP, "short header not marked as non-IP")

endmodule

[tb/testbench.sv]
module testbench;
    import pdbc_pkg::*;

    localparam int ETH_HDR = 14;
    localparam int WORD_BYTES = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 350;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT_RESULT = 900;
    localparam int BURST_FIRST = 500;
    localparam int BURST_LAST = 750;

    // One captured frame header as offered on the request channel.
    typedef struct packed {
        logic [15:0] frame_length;
        logic [3:0]  ip_header_words;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  protocol_number;
        logic [3:0]  tcp_offset_words;
    } frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] host_address = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] frame_length = '0;
    logic [3:0]  ip_header_words = '0;
    logic [31:0] source_address = '0;
    logic [31:0] dest_address = '0;
    logic [7:0]  protocol_number = '0;
    logic [3:0]  tcp_offset_words = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  direction;
    logic [1:0]  protocol_class;
    logic [15:0] payload_bytes;
    logic [63:0] uplink_total;
    logic [63:0] downlink_total;
    logic [31:0] packet_total;
    logic [31:0] category_count;

    // Predicted counter state and the configured host.
    logic [31:0] host_copy = '0;
    logic [31:0] frame_count = '0;
    logic [63:0] byte_count = '0;
    logic [31:0] ip_dir_count [2] = '{default: '0};
    logic [31:0] class_dir_count [6] = '{default: '0};
    logic [63:0] payload_dir_total [2] = '{default: '0};

    frame_t  pending_frames [$];
    frame_t  active_frame;
    frame_t  next_frame;
    result_t expected_results [$];

    int frames_sent = 0;
    int results_taken = 0;
    int error_count = 0;
    int host_writes = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    packet_direction_byte_counter #(.ETH_HEADER_BYTES(ETH_HDR)) dut (.*);

    always #2 clk = ~clk;

    // Work out the result of one frame and advance the predicted counters.
    function automatic result_t predict_frame(input frame_t f);
        result_t     r;
        int unsigned hdr_bytes;
        int unsigned idx;
        logic [1:0]  slot;
        r = '0;
        slot = SLOT_OTHER;
        frame_count += 1;
        byte_count += f.frame_length;
        if (f.ip_header_words < MIN_HDR_WORDS)
        begin
            r.direction = DIR_NOT_IP;
            r.protocol_class = CLS_OTHER;
        end
        else
        begin
            if (f.source_address == host_copy)
                r.direction = DIR_FROM_HOST;
            else if (f.dest_address == host_copy)
                r.direction = DIR_TO_HOST;
            else
                r.direction = DIR_NEITHER;

            hdr_bytes = ETH_HDR + f.ip_header_words * WORD_BYTES;
            if (f.protocol_number == PROTO_TCP)
            begin
                slot = SLOT_TCP;
                // A short TCP offset leaves the TCP header inside the payload.
                if (f.tcp_offset_words < MIN_HDR_WORDS)
                    r.protocol_class = CLS_TCP_BAD;
                else
                begin
                    r.protocol_class = CLS_TCP;
                    hdr_bytes += f.tcp_offset_words * WORD_BYTES;
                end
            end
            else if (f.protocol_number == PROTO_UDP)
            begin
                slot = SLOT_UDP;
                r.protocol_class = CLS_UDP;
                hdr_bytes += UDP_HDR_BYTES;
            end
            else
                r.protocol_class = CLS_OTHER;

            // Headers longer than the frame leave no payload.
            if (f.frame_length > hdr_bytes)
                r.payload_bytes = 16'(f.frame_length - hdr_bytes);

            if (r.direction != DIR_NEITHER)
            begin
                idx = (r.direction == DIR_FROM_HOST) ? 0 : 1;
                ip_dir_count[idx] += 1;
                if (r.protocol_class == CLS_TCP_BAD)
                    r.category_count = ip_dir_count[idx];
                else
                begin
                    class_dir_count[idx * 3 + slot] += 1;
                    r.category_count = class_dir_count[idx * 3 + slot];
                end
                payload_dir_total[idx] += r.payload_bytes;
            end
        end
        r.uplink_total = payload_dir_total[0];
        r.downlink_total = payload_dir_total[1];
        r.packet_total = frame_count;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Random frame, mostly well formed and addressed to or from the host.
    function automatic frame_t make_random_frame(input logic [31:0] host);
        frame_t f;
        int     pick;
        f.source_address = $urandom;
        f.dest_address = $urandom;
        pick = $urandom_range(99);
        if (pick < 60)
            f.frame_length = 16'($urandom_range(1600, 40));
        else if (pick < 80)
            f.frame_length = 16'($urandom_range(65535));
        else
            f.frame_length = 16'($urandom_range(150));
        if ($urandom_range(99) < 85)
            f.ip_header_words = 4'($urandom_range(15, 5));
        else
            f.ip_header_words = 4'($urandom_range(4));
        pick = $urandom_range(99);
        if (pick < 40)
            f.source_address = host;
        else if (pick < 75)
            f.dest_address = host;
        else if (pick < 85)
        begin
            f.source_address = host;
            f.dest_address = host;
        end
        pick = $urandom_range(99);
        if (pick < 40)
            f.protocol_number = PROTO_TCP;
        else if (pick < 75)
            f.protocol_number = PROTO_UDP;
        else
            f.protocol_number = 8'($urandom_range(255));
        if ($urandom_range(99) < 85)
            f.tcp_offset_words = 4'($urandom_range(15, 5));
        else
            f.tcp_offset_words = 4'($urandom_range(4));
        return f;
    endfunction

    task automatic push_frame(input logic [15:0] flen, input logic [3:0] ipw,
                              input logic [31:0] src, input logic [31:0] dst,
                              input logic [7:0] proto, input logic [3:0] tcpw);
        pending_frames.push_back('{flen, ipw, src, dst, proto, tcpw});
    endtask

    // Hold off until every request has been answered, then let the pipe settle.
    task automatic wait_drained();
        while (pending_frames.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_host(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        host_address <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        host_copy = value;
        host_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [31:0] host);
        wait_drained();
        write_host(host);
        repeat (RANDOM_PER_PHASE) pending_frames.push_back(make_random_frame(host));
    endtask

    // Request driver: feeds frames from the pending queue with random gaps, none during the burst window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(predict_frame(active_frame));
                frames_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_frames.size() != 0 &&
                    ((frames_sent >= BURST_FIRST && frames_sent < BURST_LAST) ||
                     $urandom_range(99) >= 25))
                begin
                    next_frame = pending_frames.pop_front();
                    active_frame = next_frame;
                    in_valid <= 1'b1;
                    frame_length <= next_frame.frame_length;
                    ip_header_words <= next_frame.ip_header_words;
                    source_address <= next_frame.source_address;
                    dest_address <= next_frame.dest_address;
                    protocol_number <= next_frame.protocol_number;
                    tcp_offset_words <= next_frame.tcp_offset_words;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, one long hold-off, and the field checks.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    error_count++;
                end
                else
                begin
                    check_field("direction", expected_results[0].direction, direction);
                    check_field("protocol_class", expected_results[0].protocol_class,
                                protocol_class);
                    check_field("payload_bytes", expected_results[0].payload_bytes,
                                payload_bytes);
                    check_field("uplink_total", expected_results[0].uplink_total,
                                uplink_total);
                    check_field("downlink_total", expected_results[0].downlink_total,
                                downlink_total);
                    check_field("packet_total", expected_results[0].packet_total,
                                packet_total);
                    check_field("category_count", expected_results[0].category_count,
                                category_count);
                    void'(expected_results.pop_front());
                end
                results_taken++;
                if (results_taken == HOLD_AT_RESULT && !hold_done)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (results_taken >= BURST_FIRST && results_taken < BURST_LAST)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 25);
        end
    end

    // Watchdog: ends the run when no request, result or write moves for too long.
    initial
    begin
        wait (rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Sequence of phases, each with its own host address.
    initial
    begin
        logic [31:0] host;
        host = 32'hC0A8_0A01;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_host(host);

        // Directed frames: the boundaries of each header rule.
        push_frame(16'hFFFF, 4'd0, host, 32'h0000_0000, PROTO_TCP, 4'd5);
        push_frame(16'd60, 4'd4, 32'h0A00_0001, host, PROTO_UDP, 4'd0);
        push_frame(16'd54, 4'd5, host, 32'h0A00_0001, PROTO_TCP, 4'd5);
        push_frame(16'd55, 4'd5, host, 32'h0A00_0001, PROTO_TCP, 4'd5);
        push_frame(16'hFFFF, 4'd15, host, 32'hFFFF_FFFF, PROTO_TCP, 4'd15);
        push_frame(16'd1500, 4'd5, 32'h0A00_0002, host, PROTO_TCP, 4'd8);
        push_frame(16'd100, 4'd5, 32'h0A00_0003, host, PROTO_TCP, 4'd0);
        push_frame(16'd100, 4'd5, host, 32'h0A00_0004, PROTO_TCP, 4'd4);
        push_frame(16'd200, 4'd5, host, 32'h0A00_0005, PROTO_UDP, 4'd0);
        push_frame(16'd42, 4'd5, 32'h0A00_0006, host, PROTO_UDP, 4'd15);
        push_frame(16'd0, 4'd15, 32'h0A00_0007, host, PROTO_UDP, 4'd7);
        push_frame(16'd300, 4'd6, host, 32'h0A00_0008, 8'd0, 4'd3);
        push_frame(16'd300, 4'd7, 32'h0A00_0009, host, 8'd255, 4'd15);
        push_frame(16'd500, 4'd5, host, host, PROTO_TCP, 4'd5);
        push_frame(16'd500, 4'd5, host, host, PROTO_UDP, 4'd0);
        push_frame(16'd800, 4'd5, 32'h0000_0000, 32'hFFFF_FFFF, PROTO_TCP, 4'd5);
        push_frame(16'd10, 4'd5, 32'hFFFF_FFFF, 32'h0000_0000, PROTO_UDP, 4'd2);
        push_frame(16'hFFFF, 4'd15, 32'h0000_0001, 32'h0000_0002, 8'd1, 4'd0);
        push_frame(16'd100, 4'd15, host, 32'h0A00_000A, PROTO_TCP, 4'd15);
        push_frame(16'd90, 4'd5, 32'h0000_0003, 32'h0000_0004, PROTO_TCP, 4'd1);
        push_frame(16'd34, 4'd5, 32'h0A00_000B, host, 8'd50, 4'd0);

        // Random phases, the host address at both extremes and two random values.
        run_random_phase(32'h0000_0000);
        run_random_phase(32'hFFFF_FFFF);
        run_random_phase($urandom);
        run_random_phase($urandom);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Checked %0d frames over %0d host address settings: %0d mismatches.",
                 results_taken, host_writes, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
